>>> design/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/tst_pkg.sv
// Types, constants and byte-class functions for the text segment tokenizer.
// No dependencies.
`default_nettype none
package tst_pkg;

  localparam int SEGMENT_LIMIT = 1024;
  localparam int TEXT_LIMIT    = 65536;

  localparam int POS_W   = 17;
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int CNT_W   = 11;
  localparam int NSLOT   = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_PUNCT  = 2'd1,
    KIND_WORD   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    kind_t              seg_kind;
    logic [START_W-1:0] seg_position;
    logic [LEN_W-1:0]   seg_length;
    logic [CNT_W-1:0]   seg_index;
    logic               run_last;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic               word_open;
    logic [START_W-1:0] word_start;
    logic               all_digits;
    logic [CNT_W-1:0]   total;
  } tok_state_t;

  // slot 0: closed word, slot 1: one-byte segment, slot 2: end marker
  typedef struct packed {
    logic [NSLOT-1:0]            present;
    out_item_t [NSLOT-1:0]       slot;
  } step_out_t;

  localparam tok_state_t TOK_STATE_RESET = '{
    pos:        '0,
    word_open:  1'b0,
    word_start: '0,
    all_digits: 1'b1,
    total:      '0
  };

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // ASCII punctuation: ! .. /, : .. @, [ .. `, { .. ~
  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

>>> design/text_segment_tokenizer.sv
// Text segment tokenizer: one text byte per item, segments out one per item.
// Each byte is registered in the input stage, its results in the result bank.
// Throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; more results hold the input (result bank drain).
// Reset (rst, synchronous): clears input stage, result bank and scan state.
`default_nettype none
`include "assert_macros.svh"
module text_segment_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tst_pkg::out_item_t out_data
);
  import tst_pkg::*;

  logic       stg_valid;
  in_item_t   stg_item;
  tok_state_t st, st_next;
  step_out_t  res;
  logic       buf_free, advance;

  assign in_ready = !stg_valid || buf_free;
  assign advance  = stg_valid && buf_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= TOK_STATE_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

  tst_step u_step (
    .item    (stg_item),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  tst_result_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .load_valid (stg_valid),
    .res        (res),
    .buf_free   (buf_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `ASSERT_ALWAYS(a_total_bound, clk, rst, st.total <= CNT_W'(SEGMENT_LIMIT))
  `ASSERT_ALWAYS(a_pos_bound, clk, rst, st.pos <= POS_W'(TEXT_LIMIT))
  `ASSERT_NEXT(a_eot_clears, clk, rst, advance && stg_item.end_of_text,
               st.pos == '0 && !st.word_open && st.total == '0)

endmodule
`default_nettype wire

>>> design/tst_step.sv
// Per-byte tokenizer update: next state and up to three results.
// Depends on tst_pkg.
`default_nettype none
module tst_step (
  input  tst_pkg::in_item_t   item,
  input  tst_pkg::tok_state_t st,
  output tst_pkg::tok_state_t st_next,
  output tst_pkg::step_out_t  res
);
  import tst_pkg::*;

  logic               in_range, sep, pun, wch, dig, eot;
  logic               close_a, close_b, close_any, close_digits;
  logic               open1, dig1, w_emit, p_emit;
  logic [POS_W-1:0]   pos1, close_pos;
  logic [START_W-1:0] start1;
  logic [CNT_W-1:0]   total_w, total_p;
  kind_t              p_kind;

  always_comb begin
    eot      = item.end_of_text;
    in_range = (st.pos != POS_W'(TEXT_LIMIT));
    sep      = is_sep(item.char_byte);
    pun      = is_punct(item.char_byte) || (item.char_byte == CH_NUL);
    wch      = !sep && !pun;
    dig      = is_digit(item.char_byte);

    close_a = in_range && !wch && st.word_open;

    if (in_range && wch) begin
      open1  = 1'b1;
      start1 = st.word_open ? st.word_start : st.pos[START_W-1:0];
      dig1   = (st.word_open ? st.all_digits : 1'b1) & dig;
    end else if (in_range) begin
      open1  = 1'b0;
      start1 = st.word_start;
      dig1   = 1'b1;
    end else begin
      open1  = st.word_open;
      start1 = st.word_start;
      dig1   = st.all_digits;
    end
    pos1 = in_range ? st.pos + POS_W'(1) : st.pos;

    // end of text closes a word still open after this byte
    close_b      = eot && open1;
    close_any    = close_a || close_b;
    close_pos    = close_a ? st.pos : pos1;
    close_digits = close_a ? st.all_digits : dig1;

    w_emit  = close_any && (st.total < CNT_W'(SEGMENT_LIMIT));
    total_w = st.total + CNT_W'(w_emit);
    p_emit  = in_range && pun && (total_w < CNT_W'(SEGMENT_LIMIT));
    total_p = total_w + CNT_W'(p_emit);

    if (item.char_byte == CH_PERIOD || item.char_byte == CH_COMMA) begin
      p_kind = KIND_NUMBER;
    end else if (item.char_byte == CH_NUL) begin
      p_kind = KIND_WORD;
    end else begin
      p_kind = KIND_PUNCT;
    end

    res.present = {eot, p_emit, w_emit};

    res.slot[0].seg_kind     = close_digits ? KIND_NUMBER : KIND_WORD;
    res.slot[0].seg_position = start1;
    res.slot[0].seg_length   = close_pos - {1'b0, start1};
    res.slot[0].seg_index    = st.total;
    res.slot[0].run_last     = !p_emit && !eot;

    res.slot[1].seg_kind     = p_kind;
    res.slot[1].seg_position = st.pos[START_W-1:0];
    res.slot[1].seg_length   = LEN_W'(1);
    res.slot[1].seg_index    = total_w;
    res.slot[1].run_last     = !eot;

    res.slot[2].seg_kind     = KIND_END;
    res.slot[2].seg_position = '0;
    res.slot[2].seg_length   = pos1;
    res.slot[2].seg_index    = total_p;
    res.slot[2].run_last     = 1'b1;

    if (eot) begin
      st_next = TOK_STATE_RESET;
    end else begin
      st_next.pos        = pos1;
      st_next.word_open  = open1;
      st_next.word_start = start1;
      st_next.all_digits = dig1;
      st_next.total      = total_p;
    end
  end

endmodule
`default_nettype wire

>>> design/tst_result_buf.sv
// Result register bank: holds one byte's results and hands them out in order.
// Depends on tst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tst_result_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  tst_pkg::step_out_t  res,
  output logic                buf_free,
  output logic                out_valid,
  input  logic                out_ready,
  output tst_pkg::out_item_t  out_data
);
  import tst_pkg::*;

  logic [NSLOT-1:0]      mask, mask_next;
  out_item_t [NSLOT-1:0] slots;
  logic                  pop, load;

  assign out_valid = |mask;
  assign pop       = out_valid && out_ready;
  // free when empty or the last pending result leaves this cycle
  assign buf_free  = (mask == '0) || (out_ready && $onehot(mask));
  assign load      = load_valid && buf_free;

  always_comb begin
    if (load) begin
      mask_next = res.present;
    end else if (pop) begin
      mask_next = mask & (mask - NSLOT'(1));  // drop lowest pending slot
    end else begin
      mask_next = mask;
    end
  end

  always_comb begin
    if (mask[0]) begin
      out_data = slots[0];
    end else if (mask[1]) begin
      out_data = slots[1];
    end else begin
      out_data = slots[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= res.slot;
    end
  end

  `ASSERT_NEXT(a_pop_count, clk, rst, pop && !load,
               $countones(mask) == $past($countones(mask)) - 1)
  `ASSERT_IMPLIES(a_last_flag, clk, rst, out_valid && $onehot(mask), out_data.run_last)
  `ASSERT_IMPLIES(a_end_last, clk, rst, out_valid && out_data.seg_kind == KIND_END,
                  out_data.run_last && $onehot(mask))

endmodule
`default_nettype wire

>>> test/tb_text_segment_tokenizer.sv
`timescale 1ns / 1ps
// Testbench for text_segment_tokenizer: text bytes in, segment items out.
// Depends on tst_pkg and the tokenizer RTL; a scoreboard class predicts each segment.
import tst_pkg::*;

class segment_scoreboard;
  typedef enum {BYTE_GAP, BYTE_MARK, BYTE_TEXT} byte_cls_t;

  bit [16:0] scan_pos;
  bit        in_word;
  bit [15:0] word_from;
  bit        word_numeric;
  bit [10:0] seg_count;

  out_item_t due_segments[$];
  out_item_t batch[$];
  int        mismatches;

  function new();
    restart_text();
    mismatches = 0;
  endfunction

  function void restart_text();
    scan_pos     = '0;
    in_word      = 1'b0;
    word_from    = '0;
    word_numeric = 1'b1;
    seg_count    = '0;
  endfunction

  function byte_cls_t classify(logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return BYTE_GAP;
    if (c == CH_NUL) return BYTE_MARK;
    if ((c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
        (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E)) return BYTE_MARK;
    return BYTE_TEXT;
  endfunction

  // segments past the per-text limit vanish without a trace
  function void add_segment(kind_t k, logic [15:0] at, logic [16:0] len);
    out_item_t s;
    if (seg_count >= SEGMENT_LIMIT) return;
    s.seg_kind     = k;
    s.seg_position = at;
    s.seg_length   = len;
    s.seg_index    = seg_count;
    s.run_last     = 1'b0;
    batch.push_back(s);
    seg_count++;
  endfunction

  function void close_word();
    if (!in_word) return;
    add_segment(word_numeric ? KIND_NUMBER : KIND_WORD, word_from,
                scan_pos - {1'b0, word_from});
    in_word      = 1'b0;
    word_numeric = 1'b1;
  endfunction

  function void take_byte(in_item_t it);
    out_item_t marker;
    kind_t     k;
    batch.delete();
    // bytes beyond the text length limit are dropped, but an end mark still counts
    if (scan_pos < TEXT_LIMIT) begin
      case (classify(it.char_byte))
        BYTE_GAP: close_word();
        BYTE_MARK: begin
          close_word();
          if (it.char_byte == CH_PERIOD || it.char_byte == CH_COMMA) k = KIND_NUMBER;
          else if (it.char_byte == CH_NUL) k = KIND_WORD;
          else k = KIND_PUNCT;
          add_segment(k, scan_pos[15:0], 17'd1);
        end
        default: begin
          if (!in_word) begin
            in_word      = 1'b1;
            word_from    = scan_pos[15:0];
            word_numeric = 1'b1;
          end
          if (it.char_byte < CH_ZERO || it.char_byte > CH_NINE) word_numeric = 1'b0;
        end
      endcase
      scan_pos++;
    end
    if (it.end_of_text) begin
      close_word();
      marker.seg_kind     = KIND_END;
      marker.seg_position = '0;
      marker.seg_length   = scan_pos;
      marker.seg_index    = seg_count;
      marker.run_last     = 1'b0;
      batch.push_back(marker);
      restart_text();
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[i]) due_segments.push_back(batch[i]);
  endfunction

  function void check_segment(out_item_t got);
    out_item_t want;
    if (due_segments.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected segment kind %0d pos %0d len %0d idx %0d last %0b",
                 $time, got.seg_kind, got.seg_position, got.seg_length, got.seg_index,
                 got.run_last);
      return;
    end
    want = due_segments.pop_front();
    if (got.seg_kind !== want.seg_kind || got.seg_position !== want.seg_position ||
        got.seg_length !== want.seg_length || got.seg_index !== want.seg_index ||
        got.run_last !== want.run_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: segment mismatch: expected kind %0d pos %0d len %0d idx %0d ",
                  "last %0b, got kind %0d pos %0d len %0d idx %0d last %0b"},
                 $time, want.seg_kind, want.seg_position, want.seg_length, want.seg_index,
                 want.run_last, got.seg_kind, got.seg_position, got.seg_length,
                 got.seg_index, got.run_last);
    end
  endfunction
endclass

module tb_text_segment_tokenizer;
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  segment_scoreboard sb = new();

  bit idle_on         = 1'b1;
  int feed_gap_pct    = 0;
  int drain_stall_pct = 0;
  int stall_left      = 0;

  // bit 8 marks the end of the text
  localparam logic [8:0] OPENING_BYTES [24] = '{
    9'h031, 9'h039, 9'h02E, 9'h061, 9'h0FF, 9'h000, 9'h009, 9'h030,
    9'h07E, 9'h00A, 9'h080, 9'h12C, 9'h10D, 9'h02F, 9'h03A, 9'h040,
    9'h05B, 9'h060, 9'h07B, 9'h07F, 9'h020, 9'h035, 9'h17A, 9'h100
  };

  text_segment_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: score accepted items, stall in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) sb.check_segment(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < drain_stall_pct) begin
        stall_left = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'h21, 8'h2F));
      1:       return 8'($urandom_range(8'h3A, 8'h40));
      2:       return 8'($urandom_range(8'h5B, 8'h60));
      default: return 8'($urandom_range(8'h7B, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
      3, 4:    return 8'(CH_ZERO + $urandom_range(0, 9));
      5:       return pick_punct();
      6, 7: begin
        case ($urandom_range(0, 3))
          0:       return CH_SPACE;
          1:       return CH_TAB;
          2:       return CH_LF;
          default: return CH_CR;
        endcase
      end
      8:       return $urandom_range(0, 1) ? CH_PERIOD : CH_COMMA;
      9:       return 8'($urandom_range(128, 255));
      10:      return CH_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eot);
    in_item_t it;
    if (idle_on && $urandom_range(0, 99) < feed_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    it.char_byte   = c;
    it.end_of_text = eot;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(it);
  endtask

  initial begin
    int items;
    int len;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    feed_gap_pct    = 15;
    drain_stall_pct = 15;
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i][7:0], OPENING_BYTES[i][8]);

    // mostly whole texts with random content, some raw noise with stray end marks
    items = 0;
    while (items < 200) begin
      feed_gap_pct    = pick_idle_pct();
      drain_stall_pct = pick_idle_pct();
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
        items += len;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          items++;
        end
      end
    end

    // closing text back to back with no idling on either side
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++) send_byte(pick_byte(), i == 39);
    in_valid <= 1'b0;

    while (sb.due_segments.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
